// ----- rtl/core/ikb_pkg.sv -----
// ----------------------------------------------------------------------------
// ikb_pkg: shared types and constants of the integer key encoder
// Holds the key record passed from the converter to the byte emitter and the
// byte codes of the order-preserving base-100 key format.
// ----------------------------------------------------------------------------
package ikb_pkg;

    localparam int VALUE_W     = 64;
    localparam int BYTE_W      = 8;
    localparam int DIG_W       = 7;
    localparam int NUM_DIGITS  = 10;
    localparam int IDX_W       = 4;
    localparam int BITS_STEP   = 2;
    localparam int CONV_STEPS  = VALUE_W / BITS_STEP;
    localparam int STEP_W      = $clog2(CONV_STEPS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] ZERO_KEY = 8'h15;
    localparam logic [BYTE_W-1:0] POS_BASE = 8'h17;
    localparam logic [BYTE_W-1:0] NEG_BASE = 8'h13;
    localparam logic [BYTE_W-1:0] INV_MASK = 8'hff;

    typedef logic [NUM_DIGITS-1:0][DIG_W-1:0] t_digits;

    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [IDX_W-1:0] e_cnt;
        logic [IDX_W-1:0] lo_idx;
        t_digits          digits;
    } t_key_rec;

endpackage

// ----- rtl/core/ikb_front.sv -----
// ----------------------------------------------------------------------------
// ikb_front: input stage and base-100 converter
// Accepts one integer, takes its magnitude and converts it to ten base-100
// digits, two bits per cycle, then hands a key record to the queue.
// ----------------------------------------------------------------------------
module ikb_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ikb_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_push,
    output ikb_pkg::t_key_rec                   o_rec,
    input  logic                                i_full
);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_CONV = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [ikb_pkg::STEP_W-1:0]        r_step, n_step;
    logic [ikb_pkg::VALUE_W-1:0]       r_mag, n_mag;
    logic                              r_neg, n_neg;
    logic                              r_zero, n_zero;
    ikb_pkg::t_digits                  r_dig, n_dig;
    ikb_pkg::t_digits                  step_dig;
    logic [ikb_pkg::NUM_DIGITS-1:0][1:0] carry;
    logic [ikb_pkg::IDX_W-1:0]         e_cnt;
    logic [ikb_pkg::IDX_W-1:0]         lo_idx;

    always_comb begin
        logic [1:0] cin;
        logic [8:0] v;
        logic [8:0] sub;
        for (int i = 0; i < ikb_pkg::NUM_DIGITS; i++) begin
            if (r_dig[i] >= 7'd75) begin
                carry[i] = 2'd3;
            end else if (r_dig[i] >= 7'd50) begin
                carry[i] = 2'd2;
            end else if (r_dig[i] >= 7'd25) begin
                carry[i] = 2'd1;
            end else begin
                carry[i] = 2'd0;
            end
        end
        for (int i = 0; i < ikb_pkg::NUM_DIGITS; i++) begin
            cin = (i == 0) ? r_mag[ikb_pkg::VALUE_W-1 -: 2] : carry[(i == 0) ? 0 : i - 1];
            v   = {r_dig[i], 2'b00} + {7'd0, cin};
            case (carry[i])
                2'd3:    sub = 9'd300;
                2'd2:    sub = 9'd200;
                2'd1:    sub = 9'd100;
                default: sub = 9'd0;
            endcase
            step_dig[i] = 7'(v - sub);
        end
    end

    always_comb begin
        e_cnt  = '0;
        lo_idx = '0;
        for (int i = 0; i < ikb_pkg::NUM_DIGITS; i++) begin
            if (r_dig[i] != '0) begin
                e_cnt = ikb_pkg::IDX_W'(i + 1);
            end
        end
        for (int i = ikb_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
            if (r_dig[i] != '0) begin
                lo_idx = ikb_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_zero  = r_zero;
        n_dig   = r_dig;
        o_push  = 1'b0;
        unique case (r_state)
            FS_IDLE: begin
                if (i_valid) begin
                    n_neg  = i_value[ikb_pkg::VALUE_W-1];
                    n_zero = (i_value == '0);
                    n_mag  = i_value[ikb_pkg::VALUE_W-1] ?
                             (~i_value + ikb_pkg::VALUE_W'(1)) : i_value;
                    n_dig  = '0;
                    n_step = '0;
                    n_state = (i_value == '0) ? FS_PUSH : FS_CONV;
                end
            end
            FS_CONV: begin
                n_dig  = step_dig;
                n_mag  = {r_mag[ikb_pkg::VALUE_W-3:0], 2'b00};
                n_step = r_step + 1'b1;
                if (r_step == ikb_pkg::STEP_W'(ikb_pkg::CONV_STEPS - 1)) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step <= n_step;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_dig  <= n_dig;
    end

    assign o_stall       = (r_state != FS_IDLE);
    assign o_rec.neg     = r_neg;
    assign o_rec.zero    = r_zero;
    assign o_rec.e_cnt   = e_cnt;
    assign o_rec.lo_idx  = lo_idx;
    assign o_rec.digits  = r_dig;

endmodule

// ----- rtl/core/ikb_queue.sv -----
// ----------------------------------------------------------------------------
// ikb_queue: key record queue
// A small first-in first-out buffer of key records between the converter
// and the byte emitter.
// ----------------------------------------------------------------------------
module ikb_queue #(
    parameter int DEPTH = ikb_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ikb_pkg::t_key_rec i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ikb_pkg::t_key_rec o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ikb_pkg::t_key_rec  r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];

endmodule

// ----- rtl/core/ikb_back.sv -----
// ----------------------------------------------------------------------------
// ikb_back: key byte emitter
// Takes key records from the queue and emits the header byte and the digit
// bytes, one beat per cycle while the receiver does not stall, through an output register.
// ----------------------------------------------------------------------------
module ikb_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  ikb_pkg::t_key_rec              i_q_rec,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ikb_pkg::BYTE_W-1:0]     o_key_byte,
    output logic                           o_last
);

    ikb_pkg::t_key_rec             r_rec;
    logic                          r_busy;
    logic                          r_hdr;
    logic [ikb_pkg::IDX_W-1:0]     r_idx;
    logic                          r_out_valid;
    logic [ikb_pkg::BYTE_W-1:0]    r_out_byte;
    logic                          r_out_last;

    logic                          slot_free;
    logic                          emit;
    logic                          fin;
    logic [ikb_pkg::DIG_W-1:0]     dig;
    logic [ikb_pkg::BYTE_W-1:0]    hdr_byte;
    logic [ikb_pkg::BYTE_W-1:0]    dig_byte;

    assign slot_free = !r_out_valid || !i_stall;
    assign emit      = r_busy && slot_free;
    assign o_pop     = !r_busy && i_q_valid;
    assign dig       = r_rec.digits[r_idx];
    assign fin       = (r_idx == r_rec.lo_idx);
    assign hdr_byte  = r_rec.neg ?
                       (ikb_pkg::NEG_BASE - {4'd0, r_rec.e_cnt}) :
                       (ikb_pkg::POS_BASE + {4'd0, r_rec.e_cnt});
    assign dig_byte  = {dig, !fin} ^ (r_rec.neg ? ikb_pkg::INV_MASK : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && (r_hdr ? r_rec.zero : fin)) begin
                r_busy <= 1'b0;
            end
            if (slot_free) begin
                r_out_valid <= emit;
            end
        end
        if (o_pop) begin
            r_rec <= i_q_rec;
            r_hdr <= 1'b1;
        end else if (emit) begin
            if (r_hdr) begin
                r_hdr <= 1'b0;
                r_idx <= r_rec.e_cnt - 1'b1;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
        if (emit) begin
            if (r_hdr) begin
                r_out_byte <= r_rec.zero ? ikb_pkg::ZERO_KEY : hdr_byte;
                r_out_last <= r_rec.zero;
            end else begin
                r_out_byte <= dig_byte;
                r_out_last <= fin;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_key_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

// ----- rtl/core/integer_key_base100_encoder.sv -----
// ----------------------------------------------------------------------------
// integer_key_base100_encoder: order-preserving base-100 integer key encoder
// Turns one signed 64-bit integer into key bytes whose byte order matches
// the numeric order.
// ----------------------------------------------------------------------------
// The input channel takes one signed integer per beat on i_value, qualified
// by i_valid and held off by o_stall. The output channel gives one key byte
// per beat on o_key_byte with o_last marking the final byte of the key; the
// receiver holds it with i_stall. A key is 1 to 11 beats long.
// The converter turns a nonzero value into ten base-100 digits, two magnitude
// bits per cycle, and then hands the record on; a zero skips the conversion.
// The converter takes no new value until it has handed on the record of the
// last one, while the emitter sends the bytes of a key one per cycle unless
// the receiver stalls.
// A queue between converter and emitter lets the next value be converted
// while the previous key is still being sent.
// Reset is synchronous and empties the queue and the output register; no
// beat is in flight afterward. When the receiver stalls, the output byte
// holds, the emitter waits, and once the queue fills the converter and then
// the input channel stall as well.
// ----------------------------------------------------------------------------
module integer_key_base100_encoder #(
    parameter int QUEUE_DEPTH = ikb_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ikb_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ikb_pkg::BYTE_W-1:0]          o_key_byte,
    output logic                                o_last
);

    logic              push;
    logic              full;
    logic              pop;
    logic              q_valid;
    ikb_pkg::t_key_rec front_rec;
    ikb_pkg::t_key_rec q_rec;

    ikb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_push  (push),
        .o_rec   (front_rec),
        .i_full  (full)
    );

    ikb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    ikb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_rec    (q_rec),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_key_byte (o_key_byte),
        .o_last     (o_last)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: integer key base-100 encoder
// Sends signed 64-bit integers into the encoder and checks every key byte
// beat it returns against keys predicted in the bench, in arrival order. The
// input values mix extremes, values with trailing zero digits and full random
// words. Both sides idle at random, the receiver once holds off long enough
// to back the encoder up into its input, and a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [ikb_pkg::BYTE_W-1:0] key_byte;
        logic                       last;
    } t_key_beat;

    class key_scoreboard;
        t_key_beat expected_beats[$];
        int        error_count;

        function new();
            error_count = 0;
        endfunction

        function void note_value(logic signed [ikb_pkg::VALUE_W-1:0] value);
            logic [ikb_pkg::VALUE_W-1:0] mag;
            logic [6:0]                  digits [ikb_pkg::NUM_DIGITS];
            logic [ikb_pkg::BYTE_W-1:0]  b;
            logic                        neg;
            int                          e_cnt;
            int                          lo_idx;
            int                          i;
            if (value == 0) begin
                expected_beats.push_back('{ikb_pkg::ZERO_KEY, 1'b1});
                return;
            end
            neg = value[ikb_pkg::VALUE_W-1];
            mag = neg ? (~value + 64'd1) : value;
            e_cnt = 0;
            while (mag != 0 && e_cnt < ikb_pkg::NUM_DIGITS) begin
                digits[e_cnt] = 7'(mag % 100);
                mag = mag / 100;
                e_cnt++;
            end
            lo_idx = 0;
            while (lo_idx < e_cnt - 1 && digits[lo_idx] == 0) begin
                lo_idx++;
            end
            b = neg ? (ikb_pkg::NEG_BASE - 8'(e_cnt)) : (ikb_pkg::POS_BASE + 8'(e_cnt));
            expected_beats.push_back('{b, 1'b0});
            for (i = e_cnt - 1; i >= lo_idx; i--) begin
                b = {1'b0, digits[i]} * 8'd2 + ((i == lo_idx) ? 8'd0 : 8'd1);
                if (neg) begin
                    b = b ^ ikb_pkg::INV_MASK;
                end
                expected_beats.push_back('{b, (i == lo_idx)});
            end
        endfunction

        function void check_beat(logic [ikb_pkg::BYTE_W-1:0] key_byte, logic last);
            t_key_beat want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected key beat, got byte %02h last %0b",
                         $time, key_byte, last);
                error_count++;
                return;
            end
            want = expected_beats.pop_front();
            if (key_byte !== want.key_byte) begin
                $display("%0t: key byte mismatch, expected %02h, got %02h",
                         $time, want.key_byte, key_byte);
                error_count++;
            end
            if (last !== want.last) begin
                $display("%0t: last flag mismatch, expected %0b, got %0b",
                         $time, want.last, last);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                                i_clk      = 1'b0;
    logic                                i_rst_n    = 1'b0;
    logic                                i_valid    = 1'b0;
    logic signed [ikb_pkg::VALUE_W-1:0]  i_value    = '0;
    logic                                i_stall    = 1'b0;
    logic                                o_stall;
    logic                                o_valid;
    logic [ikb_pkg::BYTE_W-1:0]          o_key_byte;
    logic                                o_last;

    key_scoreboard board = new();
    bit            calm = 1'b0;
    int            hold_off_cycles = 0;

    integer_key_base100_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_key_byte (o_key_byte),
        .o_last     (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic longint draw_value();
        logic [63:0] mag;
        int          r;
        int          nd;
        int          tz;
        int          k;
        r = $urandom_range(0, 9);
        if (r < 3) return {$urandom, $urandom};
        if (r == 8) return longint'($urandom_range(0, 400)) - 200;
        if (r == 9) begin
            if ($urandom_range(0, 1) == 1)
                return 64'sh7FFF_FFFF_FFFF_FFFF - longint'($urandom_range(0, 300));
            return 64'sh8000_0000_0000_0000 + longint'($urandom_range(0, 300));
        end
        nd = $urandom_range(1, 10);
        tz = ($urandom_range(0, 1) == 1) ? $urandom_range(0, nd - 1) : 0;
        mag = 64'((nd == 10) ? $urandom_range(1, 8) : $urandom_range(1, 99));
        for (k = 1; k < nd; k++) begin
            mag = mag * 100 + ((k >= nd - tz) ? 64'd0 : 64'($urandom_range(0, 99)));
        end
        return ($urandom_range(0, 1) == 1) ? -longint'(mag) : longint'(mag);
    endfunction

    task automatic send_value(input longint value);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        board.note_value(value);
    endtask

    initial begin : receiver
        int stall_left;
        int n;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
                board.check_beat(o_key_byte, o_last);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (hold_off_cycles > 0) begin
                i_stall <= 1'b1;
                stall_left = hold_off_cycles - 1;
                hold_off_cycles = 0;
            end else begin
                n = calm ? 0 : (($urandom_range(0, 3) == 0) ? pick_gap() : 0);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    stall_left = n - 1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_value(64'sd0);
        send_value(64'sd1);
        send_value(-64'sd1);
        send_value(64'sd50);
        send_value(-64'sd50);
        send_value(64'sd99);
        send_value(-64'sd99);
        send_value(64'sd100);
        send_value(-64'sd100);
        send_value(64'sd101);
        send_value(64'sd9999);
        send_value(64'sd10000);
        send_value(-64'sd42000000);
        send_value(64'sd123456789);
        send_value(64'sd98765432100);
        send_value(64'sd1000000000000000000);
        send_value(-64'sd1000000000000000000);
        send_value(64'sh7FFF_FFFF_FFFF_FFFF);
        send_value(64'sh8000_0000_0000_0001);
        send_value(64'sh8000_0000_0000_0000);
        send_value(-64'sd9000000000000000000);
        send_value(64'sd0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150) hold_off_cycles = 400;
            calm = (n >= 250 && n < 320);
            send_value(draw_value());
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
